// ===== sv/accumulator_stack_vm_execute_defines.svh =====
// Assertion macros for the accumulator stack machine execute block.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef ACCUMULATOR_STACK_VM_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_STACK_VM_EXECUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define ASVM_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);
`define ASVM_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);
`else
`define ASVM_ASSERT_IMP(lbl, ant, cons, msg)
`define ASVM_ASSERT_NXT(lbl, ant, cons, msg)
`endif
`endif

// ===== sv/asvm_pkg.sv =====
// Shared types and constants for the accumulator stack machine execute block.
// No dependencies; used by asvm_alu and accumulator_stack_vm_execute.
package asvm_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int LOCAL_COUNT = 256;
	localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int LOCAL_AW    = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

	localparam logic [LVL_W-1:0] LVL_FULL   = LVL_W'(STACK_DEPTH);
	localparam logic [31:0]      LOCAL_LIMIT = 32'(LOCAL_COUNT);

	typedef enum logic [4:0] {
		OP_BEGIN    = 5'd0,
		OP_LDIMM    = 5'd1,
		OP_LDLOC    = 5'd2,
		OP_STLOC    = 5'd3,
		OP_SETSTATE = 5'd4,
		OP_PUSHIMM  = 5'd5,
		OP_BZ       = 5'd6,
		OP_BNZ      = 5'd7,
		OP_PUSHA    = 5'd8,
		OP_POP      = 5'd9,
		OP_OR       = 5'd10,
		OP_XOR      = 5'd11,
		OP_AND      = 5'd12,
		OP_EQ       = 5'd13,
		OP_NE       = 5'd14,
		OP_LTU      = 5'd15,
		OP_LTS      = 5'd16,
		OP_GTU      = 5'd17,
		OP_GTS      = 5'd18,
		OP_LEU      = 5'd19,
		OP_LES      = 5'd20,
		OP_GEU      = 5'd21,
		OP_GES      = 5'd22,
		OP_SHL      = 5'd23,
		OP_SHRU     = 5'd24,
		OP_SHRS     = 5'd25,
		OP_ADD      = 5'd26,
		OP_SUB      = 5'd27,
		OP_MUL      = 5'd28,
		OP_RET      = 5'd29,
		OP_HALT     = 5'd30,
		OP_BAD      = 5'd31
	} op_t;

	typedef enum logic [2:0] {
		ST_EXEC  = 3'd0,
		ST_READY = 3'd1,
		ST_HALT  = 3'd2,
		ST_BADOP = 3'd3,
		ST_FAULT = 3'd4
	} status_t;

	function automatic logic is_alu(input op_t o);
		return (o >= OP_OR) && (o <= OP_MUL);
	endfunction

endpackage

// ===== sv/asvm_alu.sv =====
// ALU of the execute block: computes "top op accumulator" for the ALU opcodes.
// Depends on asvm_pkg for the opcode type.
module asvm_alu (
	input  asvm_pkg::op_t op,
	input  logic [31:0]   t,
	input  logic [31:0]   a,
	output logic [31:0]   result
);

	logic        big_shift;
	logic [4:0]  sh;
	logic [63:0] prod;

	assign big_shift = |a[31:5];
	assign sh        = a[4:0];
	assign prod      = {32'd0, t} * {32'd0, a};

	always_comb begin
		case (op)
			asvm_pkg::OP_OR:   result = t | a;
			asvm_pkg::OP_XOR:  result = t ^ a;
			asvm_pkg::OP_AND:  result = t & a;
			asvm_pkg::OP_EQ:   result = {31'd0, t == a};
			asvm_pkg::OP_NE:   result = {31'd0, t != a};
			asvm_pkg::OP_LTU:  result = {31'd0, t < a};
			asvm_pkg::OP_LTS:  result = {31'd0, $signed(t) < $signed(a)};
			asvm_pkg::OP_GTU:  result = {31'd0, t > a};
			asvm_pkg::OP_GTS:  result = {31'd0, $signed(t) > $signed(a)};
			asvm_pkg::OP_LEU:  result = {31'd0, t <= a};
			asvm_pkg::OP_LES:  result = {31'd0, $signed(t) <= $signed(a)};
			asvm_pkg::OP_GEU:  result = {31'd0, t >= a};
			asvm_pkg::OP_GES:  result = {31'd0, $signed(t) >= $signed(a)};
			asvm_pkg::OP_SHL:  result = big_shift ? 32'd0 : (t << sh);
			asvm_pkg::OP_SHRU: result = big_shift ? 32'd0 : (t >> sh);
			asvm_pkg::OP_SHRS: result = big_shift ? {32{t[31]}}
				: 32'($signed(t) >>> sh);
			asvm_pkg::OP_ADD:  result = t + a;
			asvm_pkg::OP_SUB:  result = t - a;
			asvm_pkg::OP_MUL:  result = prod[31:0];
			default:           result = a;
		endcase
	end

endmodule

// ===== sv/accumulator_stack_vm_execute.sv =====
// Execute stage of an accumulator-plus-stack machine; one instruction per item.
// Input accept, then the stage 1 register, then the output register; throughput one item per cycle
// while out_ready does not stall, set by the registered read of the stack and local memories with write forwarding.
// arst_n clears accumulator, stack level, chosen state, status and handshake state;
// the stack and local memories are not cleared and hold garbage until written.
// Depends on asvm_pkg, asvm_alu and accumulator_stack_vm_execute_defines.svh.
`include "accumulator_stack_vm_execute_defines.svh"
module accumulator_stack_vm_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  op,
	input  logic [31:0] operand,
	input  logic [15:0] fall_through_pc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] acc_value,
	output logic [15:0] next_pc,
	output logic [15:0] next_state_value,
	output logic [2:0]  status
);

	// front-end control state, updated at accept; the accumulator is updated when stage 1 retires
	logic [asvm_pkg::LVL_W-1:0] level_q;
	asvm_pkg::status_t          status_q;
	logic [15:0]                state_q;
	logic [31:0]                acc_q;

	// stage 1
	logic                          s1_valid;
	asvm_pkg::op_t                 op_s1;
	logic [31:0]                   opd_s1;
	logic [15:0]                   pc_s1;
	logic                          exe_s1;
	logic [asvm_pkg::STACK_AW-1:0] stk_addr_s1;
	logic                          loc_in_s1;
	asvm_pkg::status_t             status_s1;
	logic [15:0]                   state_s1;
	logic [31:0]                   stk_rd_s1;
	logic [31:0]                   loc_rd_s1;

	// output register
	logic [31:0]       acc_out_q;
	logic [15:0]       npc_out_q;
	logic [15:0]       state_out_q;
	asvm_pkg::status_t status_out_q;
	logic              out_valid_q;

	// last write of each memory, for forwarding
	logic                          stk_lw_vld_q;
	logic [asvm_pkg::STACK_AW-1:0] stk_lw_addr_q;
	logic [31:0]                   stk_lw_data_q;
	logic                          loc_lw_vld_q;
	logic [asvm_pkg::LOCAL_AW-1:0] loc_lw_addr_q;
	logic [31:0]                   loc_lw_data_q;

	logic [31:0] stack_mem [asvm_pkg::STACK_DEPTH];
	logic [31:0] local_mem [asvm_pkg::LOCAL_COUNT];

	logic                          accept;
	logic                          s1_fire;
	asvm_pkg::op_t                 op_in;
	logic                          active;
	logic                          nx_exe;
	logic [asvm_pkg::LVL_W-1:0]    nx_level;
	asvm_pkg::status_t             nx_status;
	logic [15:0]                   nx_state;
	logic [asvm_pkg::LVL_W-1:0]    level_dec;
	logic [asvm_pkg::STACK_AW-1:0] pop_addr;
	logic [asvm_pkg::STACK_AW-1:0] push_addr;
	logic                          is_pop_in;
	logic [asvm_pkg::LOCAL_AW-1:0] loc_rd_addr;

	logic [31:0]                   top_word;
	logic [31:0]                   loc_word;
	logic [31:0]                   alu_res;
	logic [31:0]                   acc_nx;
	logic [15:0]                   npc_nx;
	logic                          stk_we;
	logic [31:0]                   stk_wdata;
	logic                          loc_we;
	logic [asvm_pkg::LOCAL_AW-1:0] loc_waddr;

	assign s1_fire  = s1_valid && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid || s1_fire;
	assign accept   = in_valid && in_ready;
	assign op_in    = asvm_pkg::op_t'(op);
	assign active   = (status_q == asvm_pkg::ST_EXEC) || (status_q == asvm_pkg::ST_READY);

	assign level_dec   = level_q - asvm_pkg::LVL_W'(1);
	assign pop_addr    = level_dec[asvm_pkg::STACK_AW-1:0];
	assign push_addr   = level_q[asvm_pkg::STACK_AW-1:0];
	assign is_pop_in   = (op_in == asvm_pkg::OP_POP) || asvm_pkg::is_alu(op_in);
	assign loc_rd_addr = operand[asvm_pkg::LOCAL_AW-1:0];

	// decide stack level, status and chosen state at accept; none depends on accumulator or memory data
	always_comb begin
		nx_exe    = 1'b0;
		nx_level  = level_q;
		nx_status = status_q;
		nx_state  = state_q;
		if (active) begin
			nx_exe    = 1'b1;
			nx_status = asvm_pkg::ST_EXEC;
			case (op_in)
				asvm_pkg::OP_BEGIN: begin
					nx_level = '0;
				end
				asvm_pkg::OP_SETSTATE: begin
					nx_state = operand[15:0];
				end
				asvm_pkg::OP_PUSHIMM, asvm_pkg::OP_PUSHA: begin
					if (level_q >= asvm_pkg::LVL_FULL) begin
						nx_exe    = 1'b0;
						nx_status = asvm_pkg::ST_FAULT;
					end else begin
						nx_level = level_q + asvm_pkg::LVL_W'(1);
					end
				end
				asvm_pkg::OP_RET: begin
					nx_status = asvm_pkg::ST_READY;
				end
				asvm_pkg::OP_HALT: begin
					nx_status = asvm_pkg::ST_HALT;
				end
				asvm_pkg::OP_BAD: begin
					nx_status = asvm_pkg::ST_BADOP;
				end
				default: begin
					if (is_pop_in) begin
						if (level_q == '0) begin
							nx_exe    = 1'b0;
							nx_status = asvm_pkg::ST_FAULT;
						end else begin
							nx_level = level_dec;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			status_q <= asvm_pkg::ST_EXEC;
			state_q  <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				level_q  <= nx_level;
				status_q <= nx_status;
				state_q  <= nx_state;
			end
			if (accept)
				s1_valid <= 1'b1;
			else if (s1_fire)
				s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_in;
			opd_s1      <= operand;
			pc_s1       <= fall_through_pc;
			exe_s1      <= nx_exe;
			stk_addr_s1 <= is_pop_in ? pop_addr : push_addr;
			loc_in_s1   <= operand < asvm_pkg::LOCAL_LIMIT;
			status_s1   <= nx_status;
			state_s1    <= nx_state;
		end
	end

	// memories: read at accept, write when stage 1 retires
	always_ff @(posedge clk) begin
		if (stk_we)
			stack_mem[stk_addr_s1] <= stk_wdata;
		if (accept)
			stk_rd_s1 <= stack_mem[pop_addr];
	end

	always_ff @(posedge clk) begin
		if (loc_we)
			local_mem[loc_waddr] <= acc_q;
		if (accept)
			loc_rd_s1 <= local_mem[loc_rd_addr];
	end

	// the write retiring in the read cycle is missed by the memory; take it from here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_lw_vld_q <= 1'b0;
			loc_lw_vld_q <= 1'b0;
		end else begin
			if (stk_we)
				stk_lw_vld_q <= 1'b1;
			if (loc_we)
				loc_lw_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_lw_addr_q <= stk_addr_s1;
			stk_lw_data_q <= stk_wdata;
		end
		if (loc_we) begin
			loc_lw_addr_q <= loc_waddr;
			loc_lw_data_q <= acc_q;
		end
	end

	assign loc_waddr = opd_s1[asvm_pkg::LOCAL_AW-1:0];
	assign stk_we    = s1_fire && exe_s1 &&
		((op_s1 == asvm_pkg::OP_PUSHIMM) || (op_s1 == asvm_pkg::OP_PUSHA));
	assign stk_wdata = (op_s1 == asvm_pkg::OP_PUSHIMM) ? opd_s1 : acc_q;
	assign loc_we    = s1_fire && exe_s1 && (op_s1 == asvm_pkg::OP_STLOC) && loc_in_s1;

	assign top_word = (stk_lw_vld_q && (stk_lw_addr_q == stk_addr_s1)) ? stk_lw_data_q
		: stk_rd_s1;
	assign loc_word = !loc_in_s1 ? 32'd0
		: (loc_lw_vld_q && (loc_lw_addr_q == loc_waddr)) ? loc_lw_data_q
		: loc_rd_s1;

	asvm_alu u_alu (
		.op     (op_s1),
		.t      (top_word),
		.a      (acc_q),
		.result (alu_res)
	);

	always_comb begin
		acc_nx = acc_q;
		npc_nx = pc_s1;
		if (exe_s1) begin
			case (op_s1)
				asvm_pkg::OP_BEGIN: acc_nx = 32'd0;
				asvm_pkg::OP_LDIMM: acc_nx = opd_s1;
				asvm_pkg::OP_LDLOC: acc_nx = loc_word;
				asvm_pkg::OP_POP:   acc_nx = top_word;
				asvm_pkg::OP_BZ: begin
					if (acc_q == 32'd0)
						npc_nx = pc_s1 + {8'd0, opd_s1[7:0]};
				end
				asvm_pkg::OP_BNZ: begin
					if (acc_q != 32'd0)
						npc_nx = pc_s1 + {8'd0, opd_s1[7:0]};
				end
				default: begin
					if (asvm_pkg::is_alu(op_s1))
						acc_nx = alu_res;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				acc_q       <= acc_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			acc_out_q    <= acc_nx;
			npc_out_q    <= npc_nx;
			state_out_q  <= state_s1;
			status_out_q <= status_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign acc_value        = acc_out_q;
	assign next_pc          = npc_out_q;
	assign next_state_value = state_out_q;
	assign status           = status_out_q;

	`ASVM_ASSERT_IMP(a_level_bound, 1'b1, level_q <= asvm_pkg::LVL_FULL, "stack level past depth")
	`ASVM_ASSERT_NXT(a_sticky_stop, !active, $stable(status_q) && $stable(level_q), "stop not sticky")
	`ASVM_ASSERT_NXT(a_underflow, accept && active && is_pop_in && (level_q == '0), status_q == asvm_pkg::ST_FAULT, "underflow missed")
	`ASVM_ASSERT_IMP(a_write_retire, stk_we || loc_we, s1_valid && exe_s1, "write without item")

endmodule
